@@ design/mqrq_pkg.sv @@
// ----------------------------------------------------------------------------
// mqrq_pkg
// shared widths, codes and reset values of the multilevel run queue
// ----------------------------------------------------------------------------
package mqrq_pkg;

	localparam int ID_W    = 6;
	localparam int PRIO_W  = 3;
	localparam int QNT_W   = 8;
	localparam int THR_W   = 6;
	localparam int CNT_W   = 16;
	localparam int CFG_W   = 8;
	localparam int CIDX_W  = 2;

	localparam int DEF_LEVELS = 4;
	localparam int DEF_TASKS  = 64;

	localparam logic [CNT_W-1:0] CNT_MAX      = '1;
	localparam logic [QNT_W-1:0] QNT_MAX      = '1;
	localparam logic [QNT_W-1:0] QUANTUM_REST = 8'd1;

	localparam logic [QNT_W-1:0] RST_QHIGH  = 8'd10;
	localparam logic [QNT_W-1:0] RST_QNORM  = 8'd5;
	localparam logic [QNT_W-1:0] RST_QLOW   = 8'd2;
	localparam logic [THR_W-1:0] RST_THRESH = 6'd10;

	localparam logic [1:0] OP_ENQ   = 2'd0;
	localparam logic [1:0] OP_DEQ   = 2'd1;
	localparam logic [1:0] OP_BOOST = 2'd2;
	localparam logic [1:0] OP_STEAL = 2'd3;

	localparam logic [CIDX_W-1:0] REG_QHIGH  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_QNORM  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_QLOW   = 2'd2;
	localparam logic [CIDX_W-1:0] REG_THRESH = 2'd3;

	typedef struct packed {
		logic              hit;
		logic [PRIO_W-1:0] lvl;
	} pick_t;

endpackage

@@ design/mqrq_link_ram.sv @@
// ----------------------------------------------------------------------------
// mqrq_link_ram
// next-link table, one write and one registered read port
// ----------------------------------------------------------------------------
module mqrq_link_ram
	import mqrq_pkg::*;
#(
	parameter int TASKS = DEF_TASKS,
	parameter int ADDR_W = $clog2(TASKS)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [ID_W-1:0]   wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [ID_W-1:0]   rdata
);

	logic [ID_W-1:0] mem [TASKS];
	logic [ID_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/mqrq_deq_pick.sv @@
// ----------------------------------------------------------------------------
// mqrq_deq_pick
// dequeue level selection with quantum yield and quantum counter update
// ----------------------------------------------------------------------------
module mqrq_deq_pick
	import mqrq_pkg::*;
#(
	parameter int LEVELS = DEF_LEVELS
) (
	input  logic [LEVELS-1:0][CNT_W-1:0] cnt,
	input  logic [LEVELS-1:0][QNT_W-1:0] quanta,
	input  logic [LEVELS-1:0][QNT_W-1:0] quantum,
	output pick_t                        pick,
	output logic [LEVELS-1:0][QNT_W-1:0] quanta_nxt
);

	logic [LEVELS-1:0] ne;
	logic [LEVELS-1:0] below;
	logic              acc;
	logic              taken;
	logic              exh;

	always_comb begin
		for (int p = 0; p < LEVELS; p++) begin
			ne[p] = (cnt[p] != '0);
		end
	end

	always_comb begin
		below = '0;
		acc = 1'b0;
		taken = 1'b0;
		exh = 1'b0;
		pick = '0;
		quanta_nxt = quanta;
		// work below each served level
		for (int p = LEVELS - 2; p >= 0; p--) begin
			below[p] = acc;
			acc = acc | ne[p];
		end
		for (int p = 0; p < LEVELS - 1; p++) begin
			if (!taken) begin
				if (!ne[p]) begin
					quanta_nxt[p] = '0;
				end else begin
					exh = (quanta[p] >= quantum[p]);
					if (exh && below[p]) begin
						quanta_nxt[p] = '0;
					end else begin
						taken = 1'b1;
						pick.hit = 1'b1;
						pick.lvl = PRIO_W'(p);
						if (exh) begin
							quanta_nxt[p] = QNT_W'(1);
						end else if (quanta[p] != QNT_MAX) begin
							quanta_nxt[p] = quanta[p] + QNT_W'(1);
						end
					end
				end
			end
		end
	end

endmodule

@@ design/multilevel_quantum_run_queue_core.sv @@
// ----------------------------------------------------------------------------
// multilevel_quantum_run_queue_core
// multilevel round-robin run queue with quantum yield and priority boost
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low; op selects
// enqueue, dequeue, boost or steal. Every request gives exactly one result:
// done is high for one cycle with found, out_task and out_level valid, and
// the receiver cannot hold it off. busy falls in the same cycle that done
// rises, so the next request may be taken right then.
// Enqueue passes through ENQ0 and ENQ1, boost through BOOST, dequeue through
// DEQ and, when a task is picked, DEQ_WB; steal through ST_CHK and ST_NXT for
// each task passed over, ST_CHK for each served level left behind, and ST_HIT
// on a hit. The states follow from the link memory with its registered read and
// single write port: each hop of a walk is one read and one compare, and an enqueue needs two link writes.
// The per-level heads, tails, counts and quantum counters sit in flops and
// reset to empty; the configuration registers reset to 10, 5, 2 and 10. The
// link table is not cleared, every entry is written before it is followed.
// Configuration writes are taken at any edge with cfg_we high.
// ----------------------------------------------------------------------------
module multilevel_quantum_run_queue_core
	import mqrq_pkg::*;
#(
	parameter int LEVELS = DEF_LEVELS,
	parameter int TASKS  = DEF_TASKS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        op,
	input  logic [ID_W-1:0]   task_id,
	input  logic [PRIO_W-1:0] prio_level,
	output logic              done,
	output logic              found,
	output logic [ID_W-1:0]   out_task,
	output logic [PRIO_W-1:0] out_level,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int LW     = $clog2(LEVELS);
	localparam int ADDR_W = $clog2(TASKS);
	localparam logic [LW-1:0] LAST = LW'(LEVELS - 1);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_ENQ0   = 9'b000000010,
		S_ENQ1   = 9'b000000100,
		S_DEQ    = 9'b000001000,
		S_DEQ_WB = 9'b000010000,
		S_BOOST  = 9'b000100000,
		S_ST_CHK = 9'b001000000,
		S_ST_NXT = 9'b010000000,
		S_ST_HIT = 9'b100000000
	} state_t;

	state_t state_q;

	logic [QNT_W-1:0] qhigh_q, qnorm_q, qlow_q;
	logic [THR_W-1:0] thresh_q;

	logic [LEVELS-1:0][ID_W-1:0]  head_q;
	logic [LEVELS-1:0][ID_W-1:0]  tail_q;
	logic [LEVELS-1:0][CNT_W-1:0] cnt_q;
	logic [LEVELS-1:0][QNT_W-1:0] quanta_q;
	logic [LEVELS-1:0][QNT_W-1:0] quantum;
	logic [LEVELS-1:0][QNT_W-1:0] quanta_nxt;

	logic [ID_W-1:0]  id_q;
	logic [LW-1:0]    lvl_q;
	logic             id_ok_q;
	logic [LW-1:0]    sel_q;
	logic [LW-1:0]    p_q;
	logic [ID_W-1:0]  cur_q;
	logic [ID_W-1:0]  prev_q;
	logic             has_prev_q;
	logic [CNT_W-1:0] n_q;

	logic              done_q, found_q;
	logic [ID_W-1:0]   out_task_q;
	logic [PRIO_W-1:0] out_level_q;

	pick_t pick;
	logic [LW-1:0] pick_lvl;

	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [ID_W-1:0]   mem_wdata, mem_rdata;

	logic [CNT_W:0] enq_sum, boost_sum;
	logic [LW-1:0]  enq_lvl;

	always_comb begin
		for (int p = 0; p < LEVELS; p++) begin
			if (p == 0) begin
				quantum[p] = qhigh_q;
			end else if (p == 1) begin
				quantum[p] = qnorm_q;
			end else if (p == 2) begin
				quantum[p] = qlow_q;
			end else begin
				quantum[p] = QUANTUM_REST;
			end
		end
	end

	mqrq_deq_pick #(
		.LEVELS(LEVELS)
	) u_pick (
		.cnt       (cnt_q),
		.quanta    (quanta_q),
		.quantum   (quantum),
		.pick      (pick),
		.quanta_nxt(quanta_nxt)
	);

	assign pick_lvl = pick.lvl[LW-1:0];

	mqrq_link_ram #(
		.TASKS (TASKS),
		.ADDR_W(ADDR_W)
	) u_link (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign enq_lvl   = (32'(prio_level) >= LEVELS) ? LW'(1) : prio_level[LW-1:0];
	assign enq_sum   = {1'b0, cnt_q[lvl_q]} + (CNT_W + 1)'(1);
	assign boost_sum = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};

	// link memory port
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_ENQ0: begin
				mem_we = id_ok_q;
				mem_waddr = ADDR_W'(id_q);
			end
			S_ENQ1: begin
				mem_we = id_ok_q && (cnt_q[lvl_q] != '0);
				mem_waddr = ADDR_W'(tail_q[lvl_q]);
				mem_wdata = id_q;
			end
			S_DEQ: begin
				mem_re = pick.hit;
				mem_raddr = ADDR_W'(head_q[pick_lvl]);
			end
			S_BOOST: begin
				mem_we = (cnt_q[1] != '0) && (cnt_q[0] != '0);
				mem_waddr = ADDR_W'(tail_q[0]);
				mem_wdata = head_q[1];
			end
			S_ST_CHK: begin
				mem_re = (p_q != LAST) && (n_q < cnt_q[p_q]);
				mem_raddr = ADDR_W'(cur_q);
			end
			S_ST_HIT: begin
				mem_we = has_prev_q;
				mem_waddr = ADDR_W'(prev_q);
				mem_wdata = mem_rdata;
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qhigh_q <= RST_QHIGH;
			qnorm_q <= RST_QNORM;
			qlow_q <= RST_QLOW;
			thresh_q <= RST_THRESH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QHIGH:  qhigh_q <= cfg_data;
				REG_QNORM:  qnorm_q <= cfg_data;
				REG_QLOW:   qlow_q <= cfg_data;
				REG_THRESH: thresh_q <= cfg_data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
			quanta_q <= '0;
			done_q <= 1'b0;
			found_q <= 1'b0;
			out_task_q <= '0;
			out_level_q <= '0;
			has_prev_q <= 1'b0;
			p_q <= '0;
			n_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						id_q <= task_id;
						lvl_q <= enq_lvl;
						id_ok_q <= (32'(task_id) < TASKS);
						p_q <= '0;
						cur_q <= head_q[0];
						prev_q <= '0;
						has_prev_q <= 1'b0;
						n_q <= '0;
						case (op)
							OP_ENQ:   state_q <= S_ENQ0;
							OP_DEQ:   state_q <= S_DEQ;
							OP_BOOST: state_q <= S_BOOST;
							OP_STEAL: state_q <= S_ST_CHK;
							default:  state_q <= S_IDLE;
						endcase
					end
				end
				S_ENQ0: begin
					state_q <= S_ENQ1;
				end
				S_ENQ1: begin
					if (id_ok_q) begin
						quanta_q[lvl_q] <= '0;
						if (cnt_q[lvl_q] == '0) begin
							head_q[lvl_q] <= id_q;
						end
						tail_q[lvl_q] <= id_q;
						cnt_q[lvl_q] <= enq_sum[CNT_W] ? CNT_MAX : enq_sum[CNT_W-1:0];
					end
					done_q <= 1'b1;
					found_q <= 1'b0;
					out_task_q <= '0;
					out_level_q <= '0;
					state_q <= S_IDLE;
				end
				S_DEQ: begin
					quanta_q <= quanta_nxt;
					sel_q <= pick_lvl;
					if (pick.hit) begin
						state_q <= S_DEQ_WB;
					end else begin
						done_q <= 1'b1;
						found_q <= 1'b0;
						out_task_q <= '0;
						out_level_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_DEQ_WB: begin
					head_q[sel_q] <= mem_rdata;
					cnt_q[sel_q] <= cnt_q[sel_q] - CNT_W'(1);
					done_q <= 1'b1;
					found_q <= 1'b1;
					out_task_q <= head_q[sel_q];
					out_level_q <= PRIO_W'(sel_q);
					state_q <= S_IDLE;
				end
				S_BOOST: begin
					// level 1 into level 0
					if (cnt_q[1] != '0) begin
						if (cnt_q[0] == '0) begin
							head_q[0] <= head_q[1];
						end
						tail_q[0] <= tail_q[1];
						cnt_q[0] <= boost_sum[CNT_W] ? CNT_MAX : boost_sum[CNT_W-1:0];
					end
					// level 2 into the now empty level 1
					if (cnt_q[2] != '0) begin
						head_q[1] <= head_q[2];
						tail_q[1] <= tail_q[2];
						cnt_q[1] <= cnt_q[2];
						head_q[2] <= '0;
						tail_q[2] <= '0;
						cnt_q[2] <= '0;
					end else if (cnt_q[1] != '0) begin
						head_q[1] <= '0;
						tail_q[1] <= '0;
						cnt_q[1] <= '0;
					end
					done_q <= 1'b1;
					found_q <= 1'b0;
					out_task_q <= '0;
					out_level_q <= '0;
					state_q <= S_IDLE;
				end
				S_ST_CHK: begin
					if (p_q == LAST) begin
						done_q <= 1'b1;
						found_q <= 1'b0;
						out_task_q <= '0;
						out_level_q <= '0;
						state_q <= S_IDLE;
					end else if (n_q >= cnt_q[p_q]) begin
						p_q <= p_q + LW'(1);
						cur_q <= head_q[p_q + LW'(1)];
						prev_q <= '0;
						has_prev_q <= 1'b0;
						n_q <= '0;
					end else if (cur_q >= thresh_q) begin
						state_q <= S_ST_HIT;
					end else begin
						prev_q <= cur_q;
						has_prev_q <= 1'b1;
						n_q <= n_q + CNT_W'(1);
						state_q <= S_ST_NXT;
					end
				end
				S_ST_NXT: begin
					cur_q <= mem_rdata;
					state_q <= S_ST_CHK;
				end
				S_ST_HIT: begin
					if (!has_prev_q) begin
						head_q[p_q] <= mem_rdata;
					end
					if (tail_q[p_q] == cur_q) begin
						tail_q[p_q] <= prev_q;
					end
					cnt_q[p_q] <= cnt_q[p_q] - CNT_W'(1);
					done_q <= 1'b1;
					found_q <= 1'b1;
					out_task_q <= cur_q;
					out_level_q <= PRIO_W'(p_q);
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign found     = found_q;
	assign out_task  = out_task_q;
	assign out_level = out_level_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in flight");

	a_no_idle_level: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (32'(out_level) < LEVELS - 1))
		else $error("task returned from the idle level");

	a_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("link memory read and write in the same cycle");

	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEQ_WB) |-> (cnt_q[sel_q] != '0))
		else $error("dequeue from an empty level");

endmodule

@@ tb/run_queue_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// run_queue_checker
// predicts every scheduler request and compares the results of the core
// ----------------------------------------------------------------------------
// Watches the request, result and register write ports of the run queue
// core. Each accepted request runs through a local copy of the per-level
// FIFOs, link table, quantum counters and registers. The predicted pick is
// queued until done shows the result. Every result is compared field by
// field with the oldest prediction. Errors are counted for the top level.
// ----------------------------------------------------------------------------
module run_queue_checker
	import mqrq_pkg::*;
#(
	parameter int LEVELS = DEF_LEVELS,
	parameter int TASKS  = DEF_TASKS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [1:0]        op,
	input  logic [ID_W-1:0]   task_id,
	input  logic [PRIO_W-1:0] prio_level,
	input  logic              done,
	input  logic              found,
	input  logic [ID_W-1:0]   out_task,
	input  logic [PRIO_W-1:0] out_level,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output int                mismatch_count,
	output int                outstanding
);

	typedef struct packed {
		logic              found;
		logic [ID_W-1:0]   tid;
		logic [PRIO_W-1:0] lvl;
	} pick_result_t;

	pick_result_t      pending_picks[$];
	pick_result_t      oldest;
	logic [ID_W-1:0]   link_mem [TASKS];
	logic [ID_W-1:0]   head_id [LEVELS];
	logic [ID_W-1:0]   tail_id [LEVELS];
	logic [CNT_W-1:0]  depth [LEVELS];
	logic [QNT_W-1:0]  used [LEVELS];
	logic [QNT_W-1:0]  qnt_high;
	logic [QNT_W-1:0]  qnt_norm;
	logic [QNT_W-1:0]  qnt_low;
	logic [THR_W-1:0]  steal_floor;

	function automatic logic [QNT_W-1:0] level_quantum(input int lv);
		case (lv)
			0: return qnt_high;
			1: return qnt_norm;
			2: return qnt_low;
			default: return QUANTUM_REST;
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] depth_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

	function automatic pick_result_t schedule_request(input logic [1:0] o,
			input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] pr);
		pick_result_t    res;
		int              lv;
		int              p;
		int              q;
		int              n;
		logic            below;
		logic            hit;
		logic            has_prev;
		logic [ID_W-1:0] cur;
		logic [ID_W-1:0] prev;
		logic [ID_W-1:0] nxt;
		res = '0;
		hit = 1'b0;
		case (o)
			OP_ENQ: begin
				// out of range levels fall back to the normal level
				lv = (pr >= LEVELS) ? 1 : pr;
				used[lv] = '0;
				link_mem[id] = '0;
				if (depth[lv] != 0) link_mem[tail_id[lv]] = id;
				else head_id[lv] = id;
				tail_id[lv] = id;
				depth[lv] = depth_add(depth[lv], CNT_W'(1));
			end
			OP_DEQ: begin
				for (p = 0; p < LEVELS - 1 && !hit; p++) begin
					if (depth[p] == 0) begin
						used[p] = '0;
					end else begin
						below = 1'b0;
						if (used[p] >= level_quantum(p)) begin
							for (q = p + 1; q < LEVELS - 1; q++)
								if (depth[q] != 0) below = 1'b1;
							used[p] = '0;
						end
						if (!below) begin
							hit = 1'b1;
							res.tid = head_id[p];
							res.lvl = PRIO_W'(p);
							head_id[p] = link_mem[head_id[p]];
							depth[p] = depth[p] - CNT_W'(1);
							if (used[p] != QNT_MAX) used[p] = used[p] + QNT_W'(1);
						end
					end
				end
			end
			OP_BOOST: begin
				for (p = 0; p < 2; p++) begin
					if (depth[p + 1] != 0) begin
						if (depth[p] != 0) link_mem[tail_id[p]] = head_id[p + 1];
						else head_id[p] = head_id[p + 1];
						tail_id[p] = tail_id[p + 1];
						depth[p] = depth_add(depth[p], depth[p + 1]);
						head_id[p + 1] = '0;
						tail_id[p + 1] = '0;
						depth[p + 1] = '0;
					end
				end
			end
			OP_STEAL: begin
				for (p = 0; p < LEVELS - 1 && !hit; p++) begin
					cur = head_id[p];
					prev = '0;
					has_prev = 1'b0;
					for (n = 0; n < depth[p] && !hit; n++) begin
						if (cur >= steal_floor) begin
							hit = 1'b1;
							nxt = link_mem[cur];
							if (has_prev) link_mem[prev] = nxt;
							else head_id[p] = nxt;
							if (tail_id[p] == cur) tail_id[p] = prev;
							depth[p] = depth[p] - CNT_W'(1);
							res.tid = cur;
							res.lvl = PRIO_W'(p);
						end else begin
							prev = cur;
							has_prev = 1'b1;
							cur = link_mem[cur];
						end
					end
				end
			end
			default: begin
			end
		endcase
		res.found = hit;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_id[i] = '0;
				tail_id[i] = '0;
				depth[i] = '0;
				used[i] = '0;
			end
			for (int i = 0; i < TASKS; i++) link_mem[i] = '0;
			qnt_high = RST_QHIGH;
			qnt_norm = RST_QNORM;
			qnt_low = RST_QLOW;
			steal_floor = RST_THRESH;
			pending_picks.delete();
			mismatch_count = 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (pending_picks.size() == 0) begin
					$error("unexpected result: found %0d, out_task %0d, out_level %0d",
						found, out_task, out_level);
					mismatch_count++;
				end else begin
					oldest = pending_picks.pop_front();
					if (found !== oldest.found) begin
						$error("found: expected %0d, actual %0d", oldest.found, found);
						mismatch_count++;
					end
					if (out_task !== oldest.tid) begin
						$error("out_task: expected %0d, actual %0d", oldest.tid, out_task);
						mismatch_count++;
					end
					if (out_level !== oldest.lvl) begin
						$error("out_level: expected %0d, actual %0d", oldest.lvl, out_level);
						mismatch_count++;
					end
				end
			end
			if (start && !busy) begin
				pending_picks.push_back(schedule_request(op, task_id, prio_level));
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_QHIGH: qnt_high = cfg_data;
					REG_QNORM: qnt_norm = cfg_data;
					REG_QLOW: qnt_low = cfg_data;
					REG_THRESH: steal_floor = cfg_data[THR_W-1:0];
					default: begin
					end
				endcase
			end
			outstanding <= pending_picks.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the multilevel quantum run queue core
// ----------------------------------------------------------------------------
// Every task id is first queued once so that the whole link table holds
// known values. A short directed sequence follows, then random phases under
// changing quanta and steal thresholds, the extremes among them. Requests
// come in bursts with random gaps. The checker predicts and compares every
// result. This module only issues requests and register writes and reports.
// ----------------------------------------------------------------------------
module testbench;
	import mqrq_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int PHASE_REQS  = 250;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        op;
	logic [ID_W-1:0]   task_id;
	logic [PRIO_W-1:0] prio_level;
	logic              done;
	logic              found;
	logic [ID_W-1:0]   out_task;
	logic [PRIO_W-1:0] out_level;
	logic              cfg_we;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	int                mismatch_count;
	int                outstanding;
	int                cycle_count = 0;
	int                handed_out = 0;
	int                burst_left;
	int                n_enq = 0;
	int                n_deq = 0;
	int                n_boost = 0;
	int                n_steal = 0;
	int                n_settings = 0;
	logic              pacing;
	logic [DEF_TASKS-1:0] queued_map = '0;

	multilevel_quantum_run_queue_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.task_id(task_id),
		.prio_level(prio_level),
		.done(done),
		.found(found),
		.out_task(out_task),
		.out_level(out_level),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	run_queue_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.task_id(task_id),
		.prio_level(prio_level),
		.done(done),
		.found(found),
		.out_task(out_task),
		.out_level(out_level),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// rough view of which ids sit in a queue, used to keep most enqueues unique
	always @(posedge clk) begin
		logic [DEF_TASKS-1:0] next_map;
		next_map = queued_map;
		if (done && found) next_map[out_task] = 1'b0;
		if (start && !busy && op == OP_ENQ) next_map[task_id] = 1'b1;
		queued_map <= next_map;
		if (done && found) handed_out <= handed_out + 1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic issue(input logic [1:0] o, input logic [ID_W-1:0] id,
			input logic [PRIO_W-1:0] pr);
		start <= 1'b1;
		op <= o;
		task_id <= id;
		prio_level <= pr;
		@(posedge clk);
		while (busy) @(posedge clk);
		case (o)
			OP_ENQ: n_enq++;
			OP_DEQ: n_deq++;
			OP_BOOST: n_boost++;
			default: n_steal++;
		endcase
		if (pacing) begin
			if (burst_left == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
				burst_left = $urandom_range(1, 40);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_settings(input logic [CFG_W-1:0] qh, input logic [CFG_W-1:0] qn,
			input logic [CFG_W-1:0] ql, input logic [CFG_W-1:0] thr);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_QHIGH;
		cfg_data <= qh;
		@(posedge clk);
		cfg_index <= REG_QNORM;
		cfg_data <= qn;
		@(posedge clk);
		cfg_index <= REG_QLOW;
		cfg_data <= ql;
		@(posedge clk);
		cfg_index <= REG_THRESH;
		cfg_data <= thr;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic random_request();
		int                r;
		int                k;
		logic [1:0]        o;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] pr;
		r = $urandom_range(0, 99);
		if (r < 40) o = OP_ENQ;
		else if (r < 75) o = OP_DEQ;
		else if (r < 90) o = OP_STEAL;
		else o = OP_BOOST;
		id = ID_W'($urandom);
		// mostly ids that are not queued yet, the rest random and possibly duplicates
		if (o == OP_ENQ && $urandom_range(0, 9) != 0)
			for (k = 0; k < 8 && queued_map[id]; k++) id = ID_W'($urandom);
		r = $urandom_range(0, 99);
		if (r < 80) pr = PRIO_W'($urandom_range(0, 2));
		else if (r < 85) pr = PRIO_W'(DEF_LEVELS - 1);
		else pr = PRIO_W'($urandom_range(DEF_LEVELS, 7));
		issue(o, id, pr);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_ENQ;
		task_id = '0;
		prio_level = '0;
		cfg_we = 1'b0;
		cfg_index = REG_QHIGH;
		cfg_data = '0;
		burst_left = 0;
		pacing = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every id once, so no link is followed before it is written
		for (int i = 0; i < DEF_TASKS; i++) begin
			issue(OP_ENQ, ID_W'(i), PRIO_W'($urandom_range(0, 7)));
		end

		write_settings(8'd2, 8'd1, 8'd0, 8'd40);
		issue(OP_ENQ, 6'd63, 3'd0);
		issue(OP_ENQ, 6'd0, 3'd7);
		issue(OP_ENQ, 6'd62, 3'd4);
		issue(OP_ENQ, 6'd1, 3'd3);
		issue(OP_ENQ, 6'd45, 3'd2);
		issue(OP_DEQ, 6'h3F, 3'h7);
		issue(OP_DEQ, 6'h00, 3'h0);
		issue(OP_DEQ, 6'h2A, 3'h5);
		issue(OP_DEQ, 6'h15, 3'h2);
		issue(OP_BOOST, 6'h3F, 3'h7);
		issue(OP_STEAL, 6'h00, 3'h0);
		issue(OP_ENQ, 6'd5, 3'd2);
		issue(OP_ENQ, 6'd50, 3'd1);
		issue(OP_BOOST, 6'h00, 3'h0);
		issue(OP_BOOST, 6'h15, 3'h5);
		issue(OP_STEAL, 6'h3F, 3'h7);
		issue(OP_ENQ, 6'd63, 3'd0);
		issue(OP_ENQ, 6'd63, 3'd0);
		issue(OP_DEQ, 6'h00, 3'h0);
		issue(OP_DEQ, 6'h00, 3'h0);
		issue(OP_DEQ, 6'h00, 3'h0);
		issue(OP_STEAL, 6'h2A, 3'h2);
		issue(OP_DEQ, 6'h00, 3'h0);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_settings(8'd1, 8'd1, 8'd1, 8'd32 + 8'($urandom_range(0, 3) * 64));
				1: write_settings(8'd255, 8'd255, 8'd255, 8'd255);
				2: write_settings(8'd0, 8'd0, 8'd0, 8'd0);
				default: write_settings(CFG_W'($urandom_range(0, 255)),
					CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)),
					CFG_W'($urandom_range(0, 255)));
			endcase
			repeat (PHASE_REQS) random_request();
		end

		wait_idle();
		repeat (8) @(posedge clk);

		$display("summary: %0d requests, %0d enqueue, %0d dequeue, %0d boost, %0d steal",
			n_enq + n_deq + n_boost + n_steal, n_enq, n_deq, n_boost, n_steal);
		$display("summary: %0d tasks handed out, %0d register settings with zero and full quanta",
			handed_out, n_settings);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
